/* rtl/core/pwmc_pkg.sv */
`timescale 1ns / 1ps

package pwmc_pkg;

   // register file
   localparam int CFG_BITS = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int TIMER_BITS_DEF = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECIDE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAUSE    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RUN      = 2'd3;

   localparam logic [CFG_BITS-1:0] RST_DEBOUNCE = 16'd50;
   localparam logic [CFG_BITS-1:0] RST_DECIDE   = 16'd1000;
   localparam logic [CFG_BITS-1:0] RST_PAUSE    = 16'd200;
   localparam logic [CFG_BITS-1:0] RST_RUN      = 16'd500;

   // button slots, also the owner code
   localparam logic [1:0] BTN_DRV_UP   = 2'd0;
   localparam logic [1:0] BTN_DRV_DOWN = 2'd1;
   localparam logic [1:0] BTN_PAS_UP   = 2'd2;
   localparam logic [1:0] BTN_PAS_DOWN = 2'd3;

   // phase codes seen on the result
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_DEBOUNCE = 3'd1;
   localparam logic [2:0] PH_DECIDE   = 3'd2;
   localparam logic [2:0] PH_AUTO     = 3'd3;
   localparam logic [2:0] PH_MANUAL   = 3'd4;
   localparam logic [2:0] PH_PAUSE    = 3'd5;
   localparam logic [2:0] PH_REVERSE  = 3'd6;

   typedef enum logic [6:0] {
      MODE_IDLE     = 7'b0000001,
      MODE_DEBOUNCE = 7'b0000010,
      MODE_DECIDE   = 7'b0000100,
      MODE_AUTO     = 7'b0001000,
      MODE_MANUAL   = 7'b0010000,
      MODE_PAUSE    = 7'b0100000,
      MODE_REVERSE  = 7'b1000000
   } mode_type;

   function automatic logic [2:0] mode_phase(input mode_type m);
      logic [2:0] p;
      begin
         case (m)
            MODE_IDLE:     p = PH_IDLE;
            MODE_DEBOUNCE: p = PH_DEBOUNCE;
            MODE_DECIDE:   p = PH_DECIDE;
            MODE_AUTO:     p = PH_AUTO;
            MODE_MANUAL:   p = PH_MANUAL;
            MODE_PAUSE:    p = PH_PAUSE;
            MODE_REVERSE:  p = PH_REVERSE;
            default:       p = PH_IDLE;
         endcase
         return p;
      end
   endfunction

endpackage

/* rtl/core/power_window_motor_controller.sv */
`timescale 1ns / 1ps
// a result is written to the output register, or to the skid entry while rsp is stalled
// throughput: one request per cycle while req_stall is low; the state update is
// a single pass of logic between the request port and the result register
// output register plus skid: one more request is taken while rsp is stalled, then req_stall
// reset (synchronous, active high): idle, no obstacle pending, timers at their defaults

module power_window_motor_controller
   import pwmc_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_data,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_drv_up,
   input  logic                    req_drv_down,
   input  logic                    req_pas_up,
   input  logic                    req_pas_down,
   input  logic                    req_lock_on,
   input  logic                    req_top_reached,
   input  logic                    req_bottom_reached,
   input  logic                    req_obstacle_event,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_motor_up,
   output logic                    rsp_motor_down,
   output logic [2:0]              rsp_phase
);

   // compare width wide enough for both the register and the timer, plus carry
   localparam int CW = ((TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS) + 1;
   localparam logic [CW-1:0] TIMER_MAX = CW'({TIMER_BITS{1'b1}});

   // timer registers
   logic [CFG_BITS-1:0] debounce_ff, decide_ff, pause_ff, run_ff;

   // controller state
   mode_type              mode_ff, mode_in;
   logic                  going_up_ff, going_up_in;
   logic [1:0]            owner_ff, owner_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  pending_ff, pending_in;

   // result buffer
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_up_ff, rsp_up_in;
   logic       rsp_down_ff, rsp_down_in;
   logic [2:0] rsp_phase_ff, rsp_phase_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       skid_up_ff, skid_up_in;
   logic       skid_down_ff, skid_down_in;
   logic [2:0] skid_phase_ff, skid_phase_in;

   // combinational step
   logic       req_take, rsp_take;
   logic [3:0] btn;
   logic       btn_any, sel_up, lim, opp, held;
   logic [1:0] sel_idx;
   logic [CW-1:0]         timer_plus;
   logic [TIMER_BITS-1:0] timer_next;
   logic       deb_done, dec_done, pause_done, run_done;
   logic       run_mode, new_up, new_down;
   logic [2:0] new_phase;

   // a wait of n ticks is over once the advanced count reaches n (capped to the timer range);
   // n = 0 behaves as one tick
   function automatic logic wait_over(input logic [CW-1:0] t, input logic [CFG_BITS-1:0] n);
      logic [CW-1:0] lim_v;
      begin
         lim_v = (CW'(n) > TIMER_MAX) ? TIMER_MAX : CW'(n);
         return (t >= lim_v);
      end
   endfunction

   // request side stalls only while the skid entry is occupied
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // passenger buttons are masked by the lockout
   assign btn[BTN_DRV_UP]   = req_drv_up;
   assign btn[BTN_DRV_DOWN] = req_drv_down;
   assign btn[BTN_PAS_UP]   = req_pas_up && !req_lock_on;
   assign btn[BTN_PAS_DOWN] = req_pas_down && !req_lock_on;
   assign btn_any = |btn;

   assign lim  = going_up_ff ? req_top_reached : req_bottom_reached;
   assign opp  = going_up_ff ? (btn[BTN_DRV_DOWN] || btn[BTN_PAS_DOWN])
                             : (btn[BTN_DRV_UP] || btn[BTN_PAS_UP]);
   assign held = btn[owner_ff];

   // fixed priority: driver up, driver down, passenger up, passenger down
   always_comb begin
      if (btn[BTN_DRV_UP]) begin
         sel_idx = BTN_DRV_UP;
      end else if (btn[BTN_DRV_DOWN]) begin
         sel_idx = BTN_DRV_DOWN;
      end else if (btn[BTN_PAS_UP]) begin
         sel_idx = BTN_PAS_UP;
      end else begin
         sel_idx = BTN_PAS_DOWN;
      end
   end
   // even slots are the up buttons
   assign sel_up = !sel_idx[0];

   // one shared running timer; each wait compares it against its own limit
   assign timer_plus = CW'(timer_ff) + CW'(1);
   assign timer_next = timer_plus[TIMER_BITS-1:0];
   assign deb_done   = wait_over(timer_plus, debounce_ff);
   assign dec_done   = wait_over(timer_plus, decide_ff);
   assign pause_done = wait_over(timer_plus, pause_ff);
   assign run_done   = wait_over(timer_plus, run_ff);

   // mode update for one tick
   always_comb begin
      mode_in     = mode_ff;
      going_up_in = going_up_ff;
      owner_in    = owner_ff;
      timer_in    = timer_ff;
      // an obstacle stays pending until an up request or upward travel consumes it
      pending_in  = pending_ff || req_obstacle_event;
      case (mode_ff)
         MODE_IDLE: begin
            if (btn_any) begin
               if (sel_up && pending_in) begin
                  // pending obstacle cancels the up request
                  pending_in = 1'b0;
               end else if (!(sel_up ? req_top_reached : req_bottom_reached)) begin
                  going_up_in = sel_up;
                  owner_in    = sel_idx;
                  mode_in     = MODE_DEBOUNCE;
                  timer_in    = '0;
               end
            end
         end
         MODE_DEBOUNCE: begin
            if (lim) begin
               mode_in  = MODE_IDLE;
               timer_in = '0;
            end else if (going_up_ff && pending_in) begin
               pending_in = 1'b0;
               mode_in    = MODE_IDLE;
               timer_in   = '0;
            end else if (deb_done) begin
               mode_in  = MODE_DECIDE;
               timer_in = '0;
            end else begin
               timer_in = timer_next;
            end
         end
         MODE_DECIDE: begin
            if (lim) begin
               mode_in  = MODE_IDLE;
               timer_in = '0;
            end else if (going_up_ff && pending_in) begin
               pending_in = 1'b0;
               mode_in    = MODE_PAUSE;
               timer_in   = '0;
            end else if (dec_done) begin
               // still held at the decision point means manual travel
               mode_in  = held ? MODE_MANUAL : MODE_AUTO;
               timer_in = '0;
            end else begin
               timer_in = timer_next;
            end
         end
         MODE_AUTO: begin
            if (lim) begin
               mode_in  = MODE_IDLE;
               timer_in = '0;
            end else if (going_up_ff && pending_in) begin
               pending_in = 1'b0;
               mode_in    = MODE_PAUSE;
               timer_in   = '0;
            end else if (opp) begin
               mode_in  = MODE_IDLE;
               timer_in = '0;
            end
         end
         MODE_MANUAL: begin
            if (!held || lim) begin
               mode_in  = MODE_IDLE;
               timer_in = '0;
            end else if (going_up_ff && pending_in) begin
               pending_in = 1'b0;
               mode_in    = MODE_PAUSE;
               timer_in   = '0;
            end
         end
         MODE_PAUSE: begin
            if (pause_done) begin
               mode_in  = MODE_REVERSE;
               timer_in = '0;
            end else begin
               timer_in = timer_next;
            end
         end
         MODE_REVERSE: begin
            // bottom limit ends the reversal early
            if (req_bottom_reached || run_done) begin
               mode_in  = MODE_IDLE;
               timer_in = '0;
            end else begin
               timer_in = timer_next;
            end
         end
         default: begin
            mode_in  = MODE_IDLE;
            timer_in = '0;
         end
      endcase
   end

   // motor drive follows the mode after the update
   assign run_mode  = (mode_in == MODE_DECIDE) || (mode_in == MODE_AUTO) ||
                      (mode_in == MODE_MANUAL);
   assign new_up    = run_mode && going_up_in;
   assign new_down  = (run_mode && !going_up_in) || (mode_in == MODE_REVERSE);
   assign new_phase = mode_phase(mode_in);

   // result buffer: skid drains into the output register first
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_up_in     = rsp_up_ff;
      rsp_down_in   = rsp_down_ff;
      rsp_phase_in  = rsp_phase_ff;
      skid_valid_in = skid_valid_ff;
      skid_up_in    = skid_up_ff;
      skid_down_in  = skid_down_ff;
      skid_phase_in = skid_phase_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_up_in     = skid_up_ff;
            rsp_down_in   = skid_down_ff;
            rsp_phase_in  = skid_phase_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_up_in    = new_up;
            rsp_down_in  = new_down;
            rsp_phase_in = new_phase;
         end else begin
            skid_valid_in = 1'b1;
            skid_up_in    = new_up;
            skid_down_in  = new_down;
            skid_phase_in = new_phase;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= RST_DEBOUNCE;
         decide_ff   <= RST_DECIDE;
         pause_ff    <= RST_PAUSE;
         run_ff      <= RST_RUN;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_data;
            CSR_DECIDE:   decide_ff   <= csr_data;
            CSR_PAUSE:    pause_ff    <= csr_data;
            CSR_RUN:      run_ff      <= csr_data;
            default:      debounce_ff <= debounce_ff;
         endcase
      end
   end

   // controller state advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         going_up_ff <= 1'b0;
         owner_ff    <= BTN_DRV_UP;
         timer_ff    <= '0;
         pending_ff  <= 1'b0;
      end else if (req_take) begin
         mode_ff     <= mode_in;
         going_up_ff <= going_up_in;
         owner_ff    <= owner_in;
         timer_ff    <= timer_in;
         pending_ff  <= pending_in;
      end
   end

   // result valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_up_ff     <= rsp_up_in;
      rsp_down_ff   <= rsp_down_in;
      rsp_phase_ff  <= rsp_phase_in;
      skid_up_ff    <= skid_up_in;
      skid_down_ff  <= skid_down_in;
      skid_phase_ff <= skid_phase_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_motor_up   = rsp_up_ff;
   assign rsp_motor_down = rsp_down_ff;
   assign rsp_phase      = rsp_phase_ff;

   // the motor is never driven both ways
   a_motor_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_up_ff && rsp_down_ff))
      else $error("motor driven up and down at once");

   // the skid entry is only filled behind a held output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty output register");

   // upward travel always consumes a pending obstacle
   a_up_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (going_up_ff && (mode_ff == MODE_DEBOUNCE || mode_ff == MODE_DECIDE ||
                       mode_ff == MODE_AUTO || mode_ff == MODE_MANUAL)) |-> !pending_ff)
      else $error("obstacle pending during upward travel");

endmodule
